FILE: rtl/circular_fifo_with_search_top_macros.svh
// assertion macros for the circular fifo with search
`ifndef CIRCULAR_FIFO_WITH_SEARCH_TOP_MACROS_SVH
`define CIRCULAR_FIFO_WITH_SEARCH_TOP_MACROS_SVH
`ifndef SYNTHESIS
// property that holds at every edge outside reset
`define CFIFO_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// condition at one edge implies a consequence at the next edge
`define CFIFO_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CFIFO_ASSERT(lbl, clk, rst, prop, msg)
`define CFIFO_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/cfifo_pkg.sv
// shared types and constants for the circular fifo with search
package cfifo_pkg;

   localparam int DEPTH = 8;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      OP_ENQ  = 2'd0,
      OP_DEQ  = 2'd1,
      OP_SRCH = 2'd2,
      OP_NOP  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_DUP   = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic scan;
      logic deq_rd;
      logic commit;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic scan_done;
      logic rsp_free;
   } sts_type;

endpackage

FILE: rtl/cfifo_ctrl.sv
// controller state machine for the circular fifo with search
module cfifo_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_opcode,
   output logic                req_stall,
   input  cfifo_pkg::sts_type  sts,
   output cfifo_pkg::cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DEQ,
      S_COMMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   cfifo_pkg::op_type op_dec;
   logic accept;

   assign op_dec    = cfifo_pkg::op_type'(req_opcode);
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = (state_ff == S_IDLE) && req_valid;

   // command decode
   always_comb begin
      cmd.load   = accept;
      cmd.scan   = (state_ff == S_SCAN);
      cmd.deq_rd = (state_ff == S_DEQ);
      cmd.commit = (state_ff == S_COMMIT) && sts.rsp_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (op_dec)
                  cfifo_pkg::OP_ENQ:  state_in = S_SCAN;
                  cfifo_pkg::OP_SRCH: state_in = S_SCAN;
                  cfifo_pkg::OP_DEQ:  state_in = S_DEQ;
                  default:            state_in = S_COMMIT;
               endcase
            end
         end
         S_SCAN: begin
            if (sts.scan_done) state_in = S_COMMIT;
         end
         S_DEQ: state_in = S_COMMIT;
         S_COMMIT: begin
            if (sts.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/cfifo_dpath.sv
// datapath: entry memory, pointers, scan unit and result register
`include "circular_fifo_with_search_top_macros.svh"
module cfifo_dpath (
   input  logic                clock,
   input  logic                reset,
   input  cfifo_pkg::cmd_type  cmd,
   output cfifo_pkg::sts_type  sts,
   input  logic [1:0]          req_opcode,
   input  logic signed [31:0]  req_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic signed [31:0]  rsp_data,
   output logic                rsp_found,
   output logic [3:0]          rsp_occupancy
);

   localparam int PTR_W = cfifo_pkg::PTR_W;
   localparam int CNT_W = cfifo_pkg::CNT_W;

   logic [31:0] mem [cfifo_pkg::DEPTH];

   logic [PTR_W-1:0] head_ff, tail_ff, scan_ptr_ff;
   logic [PTR_W-1:0] head_in, tail_in;
   logic [CNT_W-1:0] count_ff, count_in, scan_cnt_ff;
   logic             cmp_valid_ff, found_ff;
   logic [31:0]      value_ff, rd_data_ff;
   cfifo_pkg::op_type opcode_ff;

   logic                  rsp_valid_ff, rsp_found_ff;
   cfifo_pkg::status_type rsp_status_ff;
   logic [31:0]           rsp_data_ff;
   logic [3:0]            rsp_occ_ff;

   logic                  issue, rd_en, wr_en, full, empty;
   logic [PTR_W-1:0]      rd_addr;
   cfifo_pkg::status_type status_in;
   logic [31:0]           data_in;
   logic                  found_in;

   function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(cfifo_pkg::DEPTH - 1)) return '0;
      return p + 1'b1;
   endfunction

   // scan issue and memory read port select
   assign issue   = cmd.scan && (scan_cnt_ff != count_ff);
   assign rd_en   = issue || cmd.deq_rd;
   assign rd_addr = cmd.deq_rd ? head_ff : scan_ptr_ff;

   assign full  = (count_ff == CNT_W'(cfifo_pkg::DEPTH));
   assign empty = (count_ff == '0);

   assign sts.scan_done = (scan_cnt_ff == count_ff) && !cmp_valid_ff;
   assign sts.rsp_free  = !rsp_valid_ff || !rsp_stall;

   // operation outcome at commit
   always_comb begin
      status_in = cfifo_pkg::ST_OK;
      data_in   = '0;
      found_in  = 1'b0;
      wr_en     = 1'b0;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      case (opcode_ff)
         cfifo_pkg::OP_ENQ: begin
            found_in = found_ff;
            if (full) begin
               status_in = cfifo_pkg::ST_FULL;
            end else if (found_ff) begin
               status_in = cfifo_pkg::ST_DUP;
            end else begin
               wr_en    = cmd.commit;
               tail_in  = wrap_next(tail_ff);
               count_in = count_ff + 1'b1;
            end
         end
         cfifo_pkg::OP_DEQ: begin
            if (empty) begin
               status_in = cfifo_pkg::ST_EMPTY;
            end else begin
               data_in  = rd_data_ff;
               head_in  = wrap_next(head_ff);
               count_in = count_ff - 1'b1;
            end
         end
         cfifo_pkg::OP_SRCH: found_in = found_ff;
         default: ;
      endcase
   end

   // entry memory with registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[tail_ff] <= value_ff;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   // request capture and scan compare
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         opcode_ff   <= cfifo_pkg::op_type'(req_opcode);
         value_ff    <= req_value;
         scan_ptr_ff <= head_ff;
         scan_cnt_ff <= '0;
         found_ff    <= 1'b0;
      end else if (cmd.scan) begin
         if (issue) begin
            scan_ptr_ff <= wrap_next(scan_ptr_ff);
            scan_cnt_ff <= scan_cnt_ff + 1'b1;
         end
         if (cmp_valid_ff && (rd_data_ff == value_ff)) found_ff <= 1'b1;
      end
   end

   // control registers: pointers, count, compare valid, result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmp_valid_ff <= issue;
         if (cmd.commit) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff <= status_in;
         rsp_data_ff   <= data_in;
         rsp_found_ff  <= found_in;
         rsp_occ_ff    <= 4'(count_in);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_data      = rsp_data_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_occupancy = rsp_occ_ff;

   `CFIFO_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(cfifo_pkg::DEPTH), "count over depth")
   `CFIFO_ASSERT(a_commit_free, clock, reset, !cmd.commit || sts.rsp_free, "commit overwrote result")
   `CFIFO_ASSERT_NEXT(a_state_hold, clock, reset, !cmd.commit, $stable(count_ff) && $stable(head_ff) && $stable(tail_ff), "queue state moved without commit")

endmodule

FILE: rtl/circular_fifo_with_search_top.sv
// top level of the circular fifo with search
// enqueue or search scans the held entries, dequeue reads the head, opcode 3 goes to commit
// one item at a time: a new request is taken only when the controller is back in idle
// the scan over the held entries goes through the single memory read port
// the result register lets the next item be taken while a result still waits
// synchronous reset clears pointers, count and handshake state; entries stay unwritten
module circular_fifo_with_search_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_data,
   output logic               rsp_found,
   output logic [3:0]         rsp_occupancy
);

   cfifo_pkg::cmd_type cmd;
   cfifo_pkg::sts_type sts;

   cfifo_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   cfifo_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_opcode    (req_opcode),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_data      (rsp_data),
      .rsp_found     (rsp_found),
      .rsp_occupancy (rsp_occupancy)
   );

endmodule

FILE: test/circular_fifo_with_search_checker.sv
// checker for the circular fifo with search: tracks fifo contents and compares every result
`timescale 1ns / 100ps

module circular_fifo_with_search_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic signed [31:0] req_value,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [1:0]         rsp_status,
   input  logic signed [31:0] rsp_data,
   input  logic               rsp_found,
   input  logic [3:0]         rsp_occupancy,
   output int                 fail_count,
   output int                 pending_count
);

   // one predicted result item
   typedef struct packed {
      cfifo_pkg::status_type status;
      logic [31:0]           data;
      logic                  found;
      logic [3:0]            occupancy;
   } fifo_rsp_type;

   // shadow copy of the fifo contents and pointers
   logic [31:0] shadow_store [cfifo_pkg::DEPTH];
   int          shadow_head;
   int          shadow_tail;
   int          shadow_count;

   fifo_rsp_type awaited_rsp_q [$];
   int           mismatch_total;

   // scan the occupied entries from head for a matching word
   function automatic logic shadow_holds(logic [31:0] key);
      int   idx;
      logic hit;
      idx = shadow_head;
      hit = 1'b0;
      for (int k = 0; k < shadow_count; k++) begin
         if (shadow_store[idx] == key) hit = 1'b1;
         idx = (idx + 1) % cfifo_pkg::DEPTH;
      end
      return hit;
   endfunction

   // apply one operation to the shadow fifo and return the result it gives
   function automatic fifo_rsp_type predict_fifo_op(cfifo_pkg::op_type op, logic [31:0] value);
      fifo_rsp_type r;
      r.status = cfifo_pkg::ST_OK;
      r.data   = '0;
      r.found  = 1'b0;
      case (op)
         cfifo_pkg::OP_ENQ: begin
            r.found = shadow_holds(value);
            if (shadow_count >= cfifo_pkg::DEPTH) begin
               r.status = cfifo_pkg::ST_FULL;
            end else if (r.found) begin
               r.status = cfifo_pkg::ST_DUP;
            end else begin
               shadow_store[shadow_tail] = value;
               shadow_tail  = (shadow_tail + 1) % cfifo_pkg::DEPTH;
               shadow_count = shadow_count + 1;
            end
         end
         cfifo_pkg::OP_DEQ: begin
            if (shadow_count == 0) begin
               r.status = cfifo_pkg::ST_EMPTY;
            end else begin
               r.data       = shadow_store[shadow_head];
               shadow_head  = (shadow_head + 1) % cfifo_pkg::DEPTH;
               shadow_count = shadow_count - 1;
            end
         end
         cfifo_pkg::OP_SRCH: begin
            r.found = shadow_holds(value);
         end
         default: begin
         end
      endcase
      r.occupancy = shadow_count[3:0];
      return r;
   endfunction

   // watch both channels; results are checked before a new item is predicted
   always @(posedge clock) begin
      fifo_rsp_type want;
      if (reset) begin
         shadow_head  = 0;
         shadow_tail  = 0;
         shadow_count = 0;
         awaited_rsp_q.delete();
         mismatch_total = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp_q.size() == 0) begin
               $error("result item with nothing outstanding: status %0d data %0d",
                      rsp_status, rsp_data);
               mismatch_total++;
            end else begin
               want = awaited_rsp_q.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d", want.status, rsp_status);
                  mismatch_total++;
               end
               if (rsp_data !== want.data) begin
                  $error("data mismatch: expected %0d, actual %0d",
                         $signed(want.data), rsp_data);
                  mismatch_total++;
               end
               if (rsp_found !== want.found) begin
                  $error("found mismatch: expected %0d, actual %0d", want.found, rsp_found);
                  mismatch_total++;
               end
               if (rsp_occupancy !== want.occupancy) begin
                  $error("occupancy mismatch: expected %0d, actual %0d",
                         want.occupancy, rsp_occupancy);
                  mismatch_total++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            awaited_rsp_q.push_back(
               predict_fifo_op(cfifo_pkg::op_type'(req_opcode), req_value));
         end
      end
      fail_count    <= mismatch_total;
      pending_count <= awaited_rsp_q.size();
   end

endmodule

FILE: test/circular_fifo_with_search_top_tb.sv
// testbench top for the circular fifo with search: stimulus, flow control and verdict
`timescale 1ns / 100ps

module circular_fifo_with_search_top_tb;

   localparam int RANDOM_ITEMS = 700;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_opcode;
   logic signed [31:0] req_value;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_data;
   logic               rsp_found;
   logic [3:0]         rsp_occupancy;
   int                 fail_count;
   int                 pending_count;

   bit                 req_quiet;

   circular_fifo_with_search_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_data      (rsp_data),
      .rsp_found     (rsp_found),
      .rsp_occupancy (rsp_occupancy)
   );

   circular_fifo_with_search_checker fifo_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_data      (rsp_data),
      .rsp_found     (rsp_found),
      .rsp_occupancy (rsp_occupancy),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   initial begin
      #1_000_000;
      $display("Verification failed");
      $finish;
   end

   // offer one fifo operation after a random gap and hold it until taken
   task automatic send_fifo_op(cfifo_pkg::op_type op, logic [31:0] value);
      int gap;
      gap = req_quiet ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_value  <= value;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   // result side: random stall before each item, with quiet stretches
   initial begin
      int  hold;
      int  stretch;
      bit  rsp_quiet;
      rsp_stall <= 1'b0;
      stretch = 0;
      rsp_quiet = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (stretch == 0) begin
            rsp_quiet = ($urandom_range(0, 3) == 0);
            stretch   = $urandom_range(10, 40);
         end
         stretch--;
         hold = rsp_quiet ? 0 : $urandom_range(0, 18);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // reset, directed items, random items, drain and verdict
   initial begin
      logic [31:0]       value_pool [12];
      int                enq_pct;
      int                pick;
      cfifo_pkg::op_type op;
      logic [31:0]       value;

      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_opcode <= cfifo_pkg::OP_ENQ;
      req_value  <= '0;
      req_quiet  = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty queue cases and the unused opcode
      send_fifo_op(cfifo_pkg::OP_DEQ, 32'd0);
      send_fifo_op(cfifo_pkg::OP_SRCH, 32'd0);
      send_fifo_op(cfifo_pkg::OP_NOP, 32'hFFFF_FFFF);
      // value extremes go into the queue
      send_fifo_op(cfifo_pkg::OP_ENQ, 32'h8000_0000);
      send_fifo_op(cfifo_pkg::OP_ENQ, 32'h7FFF_FFFF);
      send_fifo_op(cfifo_pkg::OP_ENQ, 32'h0000_0000);
      send_fifo_op(cfifo_pkg::OP_ENQ, 32'hFFFF_FFFF);
      send_fifo_op(cfifo_pkg::OP_ENQ, 32'h5555_5555);
      send_fifo_op(cfifo_pkg::OP_ENQ, 32'hAAAA_AAAA);
      // duplicate rejected, search hit and miss, then two enqueues fill the queue
      send_fifo_op(cfifo_pkg::OP_ENQ, 32'h0000_0000);
      send_fifo_op(cfifo_pkg::OP_SRCH, 32'h7FFF_FFFF);
      send_fifo_op(cfifo_pkg::OP_SRCH, 32'h0000_0001);
      send_fifo_op(cfifo_pkg::OP_ENQ, 32'h0000_0001);
      send_fifo_op(cfifo_pkg::OP_ENQ, 32'h0000_0002);
      // full queue, value absent and value present
      send_fifo_op(cfifo_pkg::OP_ENQ, 32'h0000_0003);
      send_fifo_op(cfifo_pkg::OP_ENQ, 32'hFFFF_FFFF);
      send_fifo_op(cfifo_pkg::OP_SRCH, 32'h8000_0000);
      send_fifo_op(cfifo_pkg::OP_NOP, 32'h0000_0000);
      // drain a few, then enqueue at the tail pointer that wrapped when the queue filled
      send_fifo_op(cfifo_pkg::OP_DEQ, 32'd0);
      send_fifo_op(cfifo_pkg::OP_DEQ, 32'd0);
      send_fifo_op(cfifo_pkg::OP_DEQ, 32'd0);
      send_fifo_op(cfifo_pkg::OP_ENQ, 32'h0000_0004);
      send_fifo_op(cfifo_pkg::OP_ENQ, 32'h8000_0000);
      send_fifo_op(cfifo_pkg::OP_SRCH, 32'h0000_0004);
      send_fifo_op(cfifo_pkg::OP_DEQ, 32'd0);

      // random items: a small value pool makes duplicates and search hits common
      foreach (value_pool[i]) value_pool[i] = $urandom;
      enq_pct = 50;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // new fill bias and sender pace every phase so the queue swings full and empty
         if (n % 35 == 0) begin
            enq_pct   = $urandom_range(15, 75);
            req_quiet = ($urandom_range(0, 3) == 0);
            value_pool[$urandom_range(0, 11)] = $urandom;
         end
         pick = $urandom_range(0, 99);
         if (pick < enq_pct) op = cfifo_pkg::OP_ENQ;
         else if (pick < 80) op = cfifo_pkg::OP_DEQ;
         else if (pick < 97) op = cfifo_pkg::OP_SRCH;
         else op = cfifo_pkg::OP_NOP;
         value = ($urandom_range(0, 9) < 6) ? value_pool[$urandom_range(0, 11)] : $urandom;
         send_fifo_op(op, value);
      end
      req_valid <= 1'b0;

      // drain outstanding results, then allow time for anything stray
      do @(posedge clock); while (pending_count != 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
